@@ rtl/core/fcw_pkg.sv @@
// Shared types, constants and tables for the flow-to-color wheel core.
package fcw_pkg;

    localparam int FLOW_WIDTH_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Request codes
    localparam logic [1:0] REQ_MEASURE = 2'd0;
    localparam logic [1:0] REQ_COLOR   = 2'd1;
    localparam logic [1:0] REQ_FRAME   = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    localparam logic [14:0] MAX_MOTION_RST = 15'd2560;
    localparam logic [15:0] RADIUS_RST     = 16'd256;
    localparam logic [15:0] RADIUS_SAT     = 16'hFFFF;

    // Full white level in Q8.16
    localparam logic [23:0] FULL = 24'hFF0000;

    // Wheel segment lengths
    localparam int RY_LEN = 15;
    localparam int YG_LEN = 6;
    localparam int GC_LEN = 4;
    localparam int CB_LEN = 11;
    localparam int BM_LEN = 13;
    localparam int MR_LEN = 6;
    localparam int WHEEL_LEN = RY_LEN + YG_LEN + GC_LEN + CB_LEN + BM_LEN + MR_LEN;
    localparam logic [5:0] WHEEL_LAST = 6'(WHEEL_LEN - 1);

    typedef logic [WHEEL_LEN-1:0][2:0][7:0] wheel_tab_t;

    // Wheel built at elaboration: [k][0]=red, [1]=green, [2]=blue
    function automatic wheel_tab_t build_wheel();
        wheel_tab_t t;
        int k;
        int i;
        int r;
        int g;
        int b;
        t = '0;
        for (k = 0; k < WHEEL_LEN; k++)
        begin
            if (k < RY_LEN)
            begin
                i = k; r = 255; g = 255 * i / RY_LEN; b = 0;
            end
            else if (k < RY_LEN + YG_LEN)
            begin
                i = k - RY_LEN; r = 255 - 255 * i / YG_LEN; g = 255; b = 0;
            end
            else if (k < RY_LEN + YG_LEN + GC_LEN)
            begin
                i = k - RY_LEN - YG_LEN; r = 0; g = 255; b = 255 * i / GC_LEN;
            end
            else if (k < RY_LEN + YG_LEN + GC_LEN + CB_LEN)
            begin
                i = k - RY_LEN - YG_LEN - GC_LEN; r = 0; g = 255 - 255 * i / CB_LEN; b = 255;
            end
            else if (k < WHEEL_LEN - MR_LEN)
            begin
                i = k - (WHEEL_LEN - MR_LEN - BM_LEN); r = 255 * i / BM_LEN; g = 0; b = 255;
            end
            else
            begin
                i = k - (WHEEL_LEN - MR_LEN); r = 255; g = 0; b = 255 - 255 * i / MR_LEN;
            end
            t[k][0] = 8'(r);
            t[k][1] = 8'(g);
            t[k][2] = 8'(b);
        end
        return t;
    endfunction

    localparam wheel_tab_t WHEEL_TAB = build_wheel();

    // atan(2^-i) in Q0.32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/core/fcw_isqrt.sv @@
// Iterative floor square root, two radicand bits per cycle.
module fcw_isqrt #(
    parameter int RW = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [RW-1:0] radicand,
    output logic          done,
    output logic [RW/2-1:0] root
);
    localparam int HW = RW / 2;
    localparam int CW = $clog2(HW + 1);

    logic [RW-1:0] rad_reg;
    logic [HW:0]   rem_reg, rem_next;
    logic [HW-1:0] root_reg, root_next;
    logic [CW-1:0] cnt_reg;
    logic          run_reg, done_reg;

    logic [HW+2:0] rem_sh, trial;
    logic          ge;

    // One digit of the root
    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[RW-1:RW-2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (HW+1)'(rem_sh - trial) : (HW+1)'(rem_sh);
        root_next = {root_reg[HW-2:0], ge};
    end

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(HW);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= {rad_reg[RW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

@@ rtl/core/fcw_div.sv @@
// Restoring divider, one quotient bit per cycle.
module fcw_div #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, q_reg;
    logic [DW-1:0] dvs_reg, rem_reg, rem_next;
    logic [CW-1:0] cnt_reg;
    logic          run_reg, done_reg;
    logic [DW:0]   rem_sh;
    logic          ge;

    // One quotient bit
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NW-1]};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_next = ge ? DW'(rem_sh - {1'b0, dvs_reg}) : DW'(rem_sh);
    end

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NW);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

@@ rtl/core/fcw_cordic.sv @@
// Vectoring CORDIC: direction of (x, y) in Q0.32 turns, one rotation per cycle.
module fcw_cordic #(
    parameter int FW    = 16,
    parameter int STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [FW-1:0] x,
    input  logic signed [FW-1:0] y,
    output logic                 done,
    output logic [31:0]          angle
);
    import fcw_pkg::*;

    localparam int CW = FW + 16;
    localparam int IW = $clog2(STEPS + 1);

    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [CW-1:0] xe, ye, dx, dy;
    logic [31:0]          z_reg;
    logic [IW-1:0]        idx_reg;
    logic                 run_reg, done_reg;

    // Scaled start vector and per-step shifts (arithmetic shift floors)
    always_comb
    begin
        xe = CW'(x) <<< 14;
        ye = CW'(y) <<< 14;
        dx = py_reg >>> idx_reg;
        dy = px_reg >>> idx_reg;
    end

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            idx_reg  <= '0;
            run_reg  <= (y != '0);
            done_reg <= (y == '0);
        end
        else if (run_reg)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == IW'(STEPS - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Rotation datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (y == '0)
            begin
                z_reg <= x[FW-1] ? 32'h80000000 : 32'h0;
            end
            else if (x[FW-1])
            begin
                px_reg <= -xe;
                py_reg <= -ye;
                z_reg  <= 32'h80000000;
            end
            else
            begin
                px_reg <= xe;
                py_reg <= ye;
                z_reg  <= 32'h0;
            end
        end
        else if (run_reg)
        begin
            if (!py_reg[CW-1])
            begin
                px_reg <= px_reg + dx;
                py_reg <= py_reg - dy;
                z_reg  <= z_reg + atan_turn(5'(idx_reg));
            end
            else
            begin
                px_reg <= px_reg - dx;
                py_reg <= py_reg + dy;
                z_reg  <= z_reg - atan_turn(5'(idx_reg));
            end
        end
    end

    assign done  = done_reg;
    assign angle = z_reg;
endmodule

@@ rtl/core/flow_to_color_wheel_core.sv @@
// Top level of the flow-to-color wheel core: sequencer, range state and color mixing.
//
// Input channel (in_valid / in_stall): one request carries req_type, flow_x,
// flow_y and flow_valid. A start-frame request resets the running maximum
// radius to 1.0. A measure request squares the vector and takes a square
// root. A color request squares, compares against the motion range, takes a
// square root and a divide, both skipped outside the range, runs the CORDIC
// and multiplies and mixes three channels. A color request with an invalid
// vector goes straight to its result. One request is in work at a time and
// in_stall is high until it is done.
// Output channel (out_valid / out_stall): one red/green/blue result per color
// request, held in an output register. When the receiver stalls, the result
// waits there; a further color request finishes its work and then waits too.
// Configuration: cfg_wr_en writes max_motion (zero selects the auto range).
// Reset: max_motion = 10.0, running maximum = 1.0, no result pending.
module flow_to_color_wheel_core #(
    parameter int FLOW_WIDTH   = fcw_pkg::FLOW_WIDTH_DEF,
    parameter int CORDIC_STEPS = fcw_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   req_type,
    input  logic signed [FLOW_WIDTH-1:0] flow_x,
    input  logic signed [FLOW_WIDTH-1:0] flow_y,
    input  logic                         flow_valid,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   red,
    output logic [7:0]                   green,
    output logic [7:0]                   blue,
    input  logic                         cfg_wr_en,
    input  logic [14:0]                  cfg_wr_data
);
    import fcw_pkg::*;

    localparam int FW = FLOW_WIDTH;
    localparam int SW = 2 * FW;
    localparam int RW = SW + 32;
    localparam int HW = RW / 2;
    localparam int MW = (SW > 32) ? SW : 32;

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQX  = 4'd1;
    localparam logic [3:0] ST_SQY  = 4'd2;
    localparam logic [3:0] ST_RR   = 4'd3;
    localparam logic [3:0] ST_CHK  = 4'd4;
    localparam logic [3:0] ST_SQRT = 4'd5;
    localparam logic [3:0] ST_DIVS = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_CORS = 4'd8;
    localparam logic [3:0] ST_CORD = 4'd9;
    localparam logic [3:0] ST_MUL  = 4'd10;
    localparam logic [3:0] ST_CHA  = 4'd11;
    localparam logic [3:0] ST_CHB  = 4'd12;
    localparam logic [3:0] ST_CHC  = 4'd13;
    localparam logic [3:0] ST_DONE = 4'd14;

    logic [3:0]  state_reg;
    logic [14:0] max_motion_reg;
    logic [15:0] radius_reg;
    logic        out_valid_reg;
    logic [7:0]  out_reg [3];
    logic [7:0]  col_reg [3];

    logic [1:0]           req_reg;
    logic signed [FW-1:0] x_reg, y_reg;
    logic [SW-1:0]        sum_reg;
    logic [31:0]          rr_reg;
    logic                 inside_reg;
    logic [16:0]          s_reg;
    logic [37:0]          p_reg;
    logic [1:0]           ch_reg;
    logic [23:0]          cv_reg;
    logic [40:0]          prod_reg;

    logic          accept;
    logic [FW-1:0] ax, ay, asel;
    logic [SW-1:0] sq;
    logic [15:0]   range;
    logic          inside_w;
    logic [RW-1:0] radicand;
    logic          sqrt_start, sqrt_done;
    logic [HW-1:0] root;
    logic          div_start, div_done;
    logic [HW-1:0] quot;
    logic          cor_start, cor_done;
    logic [31:0]   angle;
    logic [5:0]    k0, k1;
    logic [15:0]   f;
    logic [7:0]    w0, w1;
    logic [24:0]   mix;
    logic [23:0]   fin;
    logic          out_load;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // Magnitudes and the one squarer
    always_comb
    begin
        ax   = x_reg[FW-1] ? FW'(-x_reg) : FW'(x_reg);
        ay   = y_reg[FW-1] ? FW'(-y_reg) : FW'(y_reg);
        asel = (state_reg == ST_SQX) ? ax : ay;
        sq   = SW'(asel) * SW'(asel);
    end

    // Motion range and inside test
    always_comb
    begin
        range = (max_motion_reg != '0) ? {1'b0, max_motion_reg} : radius_reg;
        if (range == '0)
        begin
            range = 16'd1;
        end
        inside_w = (MW'(sum_reg) <= MW'(rr_reg));
        radicand = (req_reg == REQ_MEASURE) ? RW'(sum_reg) : {sum_reg, 32'h0};
    end

    // Unit start strobes
    assign sqrt_start = (state_reg == ST_CHK) && ((req_reg == REQ_MEASURE) || inside_w);
    assign div_start  = (state_reg == ST_DIVS);
    assign cor_start  = (state_reg == ST_CORS);

    fcw_isqrt #(.RW(RW)) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    fcw_div #(.NW(HW), .DW(16)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (root),
        .divisor  (range),
        .done     (div_done),
        .quotient (quot)
    );

    fcw_cordic #(.FW(FW), .STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .x     (x_reg),
        .y     (y_reg),
        .done  (cor_done),
        .angle (angle)
    );

    // Wheel lookup and blend of the current channel
    always_comb
    begin
        k0  = p_reg[37:32];
        f   = p_reg[31:16];
        k1  = (k0 >= WHEEL_LAST) ? 6'd0 : k0 + 6'd1;
        w0  = WHEEL_TAB[k0][ch_reg];
        w1  = WHEEL_TAB[k1][ch_reg];
        mix = 25'(17'h10000 - {1'b0, f}) * 25'(w0) + 25'(f) * 25'(w1);
        fin = inside_reg ? FULL - prod_reg[39:16] : prod_reg[25:2];
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Sequencer, configuration and range state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            max_motion_reg <= MAX_MOTION_RST;
            radius_reg     <= RADIUS_RST;
            out_valid_reg  <= 1'b0;
            ch_reg         <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_motion_reg <= cfg_wr_data;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    ch_reg <= '0;
                    if (accept)
                    begin
                        priority if (req_type == REQ_FRAME)
                        begin
                            radius_reg <= RADIUS_RST;
                        end
                        else if (req_type == REQ_MEASURE && flow_valid)
                        begin
                            state_reg <= ST_SQX;
                        end
                        else if (req_type == REQ_COLOR)
                        begin
                            state_reg <= flow_valid ? ST_SQX : ST_DONE;
                        end
                    end
                end
                ST_SQX:  state_reg <= ST_SQY;
                ST_SQY:  state_reg <= ST_RR;
                ST_RR:   state_reg <= ST_CHK;
                ST_CHK:
                begin
                    state_reg <= sqrt_start ? ST_SQRT : ST_CORS;
                end
                ST_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        if (req_reg == REQ_MEASURE)
                        begin
                            if (root[HW-1:16] != '0)
                            begin
                                radius_reg <= RADIUS_SAT;
                            end
                            else if (root[15:0] > radius_reg)
                            begin
                                radius_reg <= root[15:0];
                            end
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_DIVS;
                        end
                    end
                end
                ST_DIVS: state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_CORS;
                    end
                end
                ST_CORS: state_reg <= ST_CORD;
                ST_CORD:
                begin
                    if (cor_done)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:  state_reg <= ST_CHA;
                ST_CHA:  state_reg <= ST_CHB;
                ST_CHB:  state_reg <= ST_CHC;
                ST_CHC:
                begin
                    if (ch_reg == 2'd2)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= ST_CHA;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Request datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_type;
            x_reg      <= flow_x;
            y_reg      <= flow_y;
            col_reg[0] <= 8'h0;
            col_reg[1] <= 8'h0;
            col_reg[2] <= 8'h0;
        end
        if (state_reg == ST_SQX)
        begin
            sum_reg <= sq;
        end
        if (state_reg == ST_SQY)
        begin
            sum_reg <= sum_reg + sq;
        end
        if (state_reg == ST_RR)
        begin
            rr_reg <= 32'(range) * 32'(range);
        end
        if (state_reg == ST_CHK)
        begin
            inside_reg <= inside_w;
            s_reg      <= '0;
        end
        if (div_done && state_reg == ST_DIV)
        begin
            s_reg <= quot[16:0];
        end
        if (state_reg == ST_MUL)
        begin
            p_reg <= 38'(angle) * 38'd54;
        end
        if (state_reg == ST_CHA)
        begin
            cv_reg <= mix[23:0];
        end
        if (state_reg == ST_CHB)
        begin
            prod_reg <= inside_reg ? 41'(s_reg) * 41'(FULL - cv_reg)
                                   : 41'(cv_reg) * 41'd3;
        end
        if (state_reg == ST_CHC)
        begin
            col_reg[ch_reg] <= fin[23:16];
        end
        if (out_load)
        begin
            out_reg[0] <= col_reg[0];
            out_reg[1] <= col_reg[1];
            out_reg[2] <= col_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = out_reg[0];
    assign green     = out_reg[1];
    assign blue      = out_reg[2];
endmodule

@@ tb/flow_to_color_wheel_core_tb.sv @@
// Self-checking testbench for the flow-to-color wheel core.
module flow_to_color_wheel_core_tb;
    import fcw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected color of one request
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Predicts colors from requests and checks the block's results against them
    class color_scoreboard;
        logic [14:0] motion_range;
        logic [15:0] peak_radius;
        rgb_t        pending[$];
        int          errors;
        int          mismatches;

        function new();
            motion_range = MAX_MOTION_RST;
            peak_radius  = RADIUS_RST;
            errors       = 0;
            mismatches   = 0;
        endfunction

        function automatic logic [63:0] int_sqrt(input logic [63:0] v);
            logic [63:0] root;
            logic [63:0] bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= root + bitv)
                begin
                    v    = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        // CORDIC vectoring angle in Q0.32 turns; >>> floors toward minus infinity
        function automatic logic [31:0] heading(input longint x, input longint y);
            longint px;
            longint py;
            longint dx;
            longint dy;
            logic [31:0] z;
            z = 0;
            if (y == 0)
                return (x >= 0) ? 32'h0 : 32'h80000000;
            px = x * 16384;
            py = y * 16384;
            if (px < 0)
            begin
                px = -px;
                py = -py;
                z  = 32'h80000000;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF; i++)
            begin
                dx = py >>> i;
                dy = px >>> i;
                if (py >= 0)
                begin
                    px = px + dx;
                    py = py - dy;
                    z  = z + atan_turn(5'(i));
                end
                else
                begin
                    px = px - dx;
                    py = py + dy;
                    z  = z - atan_turn(5'(i));
                end
            end
            return z;
        endfunction

        function automatic int hue(input int k, input int ch);
            int r;
            int g;
            int b;
            if (k < 15)      begin r = 255; g = 255 * k / 15; b = 0; end
            else if (k < 21) begin r = 255 - 255 * (k - 15) / 6; g = 255; b = 0; end
            else if (k < 25) begin r = 0; g = 255; b = 255 * (k - 21) / 4; end
            else if (k < 36) begin r = 0; g = 255 - 255 * (k - 25) / 11; b = 255; end
            else if (k < 49) begin r = 255 * (k - 36) / 13; g = 0; b = 255; end
            else             begin r = 255; g = 0; b = 255 - 255 * (k - 49) / 6; end
            return (ch == 0) ? r : ((ch == 1) ? g : b);
        endfunction

        // Note one accepted request: update state, queue a color if one is due
        function void note_request(input logic [1:0] kind, input logic signed [15:0] fx,
                                   input logic signed [15:0] fy, input logic ok);
            longint x;
            longint y;
            logic [63:0] sq;
            logic [63:0] mag;
            logic [63:0] rng;
            logic [63:0] s;
            logic [63:0] p;
            logic [63:0] f;
            logic [63:0] cv;
            int k0;
            int k1;
            logic [7:0] chan[3];
            bit in_range;
            x = fx;
            y = fy;
            if (kind == REQ_FRAME)
            begin
                peak_radius = RADIUS_RST;
                return;
            end
            if (kind != REQ_MEASURE && kind != REQ_COLOR)
                return;
            sq = 64'(x * x) + 64'(y * y);
            if (kind == REQ_MEASURE)
            begin
                if (ok)
                begin
                    mag = int_sqrt(sq);
                    if (mag > 64'hFFFF)
                        mag = 64'hFFFF;
                    if (mag > peak_radius)
                        peak_radius = 16'(mag);
                end
                return;
            end
            if (!ok)
            begin
                pending.insert(pending.size(), rgb_t'(0));
                return;
            end
            rng = (motion_range != 0) ? motion_range : peak_radius;
            if (rng == 0)
                rng = 1;
            in_range = sq <= rng * rng;
            s = 0;
            if (in_range)
                s = int_sqrt(sq << 32) / rng;
            p  = 64'(heading(x, y)) * 54;
            k0 = int'(p >> 32);
            f  = (p >> 16) & 64'hFFFF;
            k1 = (k0 + 1 >= 55) ? 0 : k0 + 1;
            for (int ch = 0; ch < 3; ch++)
            begin
                cv = (65536 - f) * hue(k0, ch) + f * hue(k1, ch);
                if (in_range)
                    cv = FULL - ((s * (FULL - cv)) >> 16);
                else
                    cv = (cv * 3) >> 2;
                chan[ch] = cv[23:16];
            end
            pending.insert(pending.size(), rgb_t'({chan[0], chan[1], chan[2]}));
        endfunction

        // Compare one result with the oldest expected color
        function void check_color(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
            rgb_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result rgb=%0d,%0d,%0d", r, g, b);
                return;
            end
            want = pending.pop_front();
            if (want.r !== r || want.g !== g || want.b !== b)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("color mismatch: expected %0d,%0d,%0d got %0d,%0d,%0d",
                             want.r, want.g, want.b, r, g, b);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic        flow_valid;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;

    color_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;
    bit hold_request;
    bit hold_done;

    flow_to_color_wheel_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .flow_x(flow_x), .flow_y(flow_y), .flow_valid(flow_valid),
        .out_valid(out_valid), .out_stall(out_stall),
        .red(red), .green(green), .blue(blue),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Send one request; held until accepted, valid stays up for the next one
    task automatic send_request(input logic [1:0] kind, input logic signed [15:0] fx,
                                input logic signed [15:0] fy, input logic ok);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        flow_x     <= fx;
        flow_y     <= fy;
        flow_valid <= ok;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(kind, fx, fy, ok);
        @(negedge clk);
    endtask

    // Wait for all colors, then let a measure in flight finish before a write
    task automatic write_range(input logic [14:0] value);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.motion_range = value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random vector, mostly within a few range widths
    task automatic random_request(input int measure_pct);
        logic [1:0] kind;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        int pick;
        pick = $urandom_range(99);
        if (pick < measure_pct)
            kind = REQ_MEASURE;
        else if (pick < 95)
            kind = REQ_COLOR;
        else if (pick < 98)
            kind = REQ_FRAME;
        else
            kind = REQ_UNUSED;
        case ($urandom_range(2))
            0: begin fx = 16'($urandom); fy = 16'($urandom); end
            1: begin fx = 16'($signed($urandom_range(8191)) - 4096);
                     fy = 16'($signed($urandom_range(8191)) - 4096); end
            default: begin fx = 16'($signed($urandom_range(1023)) - 512);
                           fy = 16'($signed($urandom_range(1023)) - 512); end
        endcase
        send_request(kind, fx, fy, $urandom_range(9) != 0);
    endtask

    // Receiver: random stall, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_done   <= 1'b1;
            hold_cycles <= 600;
            out_stall   <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall   <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_color(red, green, blue);
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [14:0] ranges[4];
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_MEASURE;
        flow_x        = '0;
        flow_y        = '0;
        flow_valid    = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: axes, zero vector, extremes, invalid, unused code, frame start
        send_request(REQ_COLOR, 16'sd0, 16'sd0, 1'b1);
        send_request(REQ_COLOR, 16'sd512, 16'sd0, 1'b1);
        send_request(REQ_COLOR, -16'sd512, 16'sd0, 1'b1);
        send_request(REQ_COLOR, 16'sd0, 16'sd700, 1'b1);
        send_request(REQ_COLOR, 16'sd0, -16'sd700, 1'b1);
        send_request(REQ_COLOR, 16'sd1000, 16'sd1000, 1'b1);
        send_request(REQ_COLOR, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_request(REQ_COLOR, -16'sd32768, -16'sd32768, 1'b1);
        send_request(REQ_COLOR, -16'sd32768, 16'sh7FFF, 1'b1);
        send_request(REQ_COLOR, 16'sd2560, 16'sd0, 1'b1);
        send_request(REQ_COLOR, 16'sd123, -16'sd77, 1'b0);
        send_request(REQ_UNUSED, 16'sd5, 16'sd5, 1'b1);
        write_range(15'd0);
        send_request(REQ_COLOR, 16'sd200, 16'sd100, 1'b1);
        send_request(REQ_MEASURE, -16'sd32768, -16'sd32768, 1'b1);
        send_request(REQ_COLOR, 16'sd20000, -16'sd9000, 1'b1);
        send_request(REQ_MEASURE, 16'sd30000, 16'sd0, 1'b0);
        send_request(REQ_FRAME, 16'sd0, 16'sd0, 1'b1);
        send_request(REQ_COLOR, 16'sd200, 16'sd100, 1'b1);
        send_request(REQ_MEASURE, 16'sd900, -16'sd1200, 1'b1);
        send_request(REQ_COLOR, -16'sd300, -16'sd1100, 1'b1);
        write_range(15'h7FFF);
        send_request(REQ_COLOR, 16'sh7FFF, -16'sd32768, 1'b1);
        write_range(15'd1);
        send_request(REQ_COLOR, 16'sd1, 16'sd0, 1'b1);
        send_request(REQ_COLOR, -16'sd1, 16'sd1, 1'b1);

        // Random phases under varying idle patterns and range settings
        ranges = '{15'd0, 15'd2560, 15'd300, 15'h7FFF};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_range((ph < 4) ? ranges[ph] : 15'($urandom_range(4000)));
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            if (ph == 4)
                hold_request = 1'b1;
            for (int n = 0; n < 50; n++)
                random_request((ranges[ph % 4] == 0) ? 40 : 20);
        end
        in_valid      <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;

        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
